>>> design/sevnote_pkg.sv
// shared types, constants and helpers for the score event to note event decoder
// no dependencies; imported by the controller, the datapath and the top level
package sevnote_pkg;

   // field widths
   localparam int QTICK_W   = 16;
   localparam int VOL_W     = 8;
   localparam int CODE_W    = 8;
   localparam int DATA_W    = 8;
   localparam int KIND_W    = 2;
   localparam int OUT_TIME_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // duration datapath widths
   localparam int DUR_W       = 19;            // quarter_ticks * 6, unshifted
   localparam int SCALED_W    = 22;            // duration * 2n, n up to 3
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = SCALED_W + RECIP_W;
   localparam int TDIV_W      = 3;             // tuplet divisor 2n+1
   localparam int TUP_W       = 2;
   localparam int DIVN_W      = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTER_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VOLUME  = 1'd1;

   // register reset values
   localparam logic [QTICK_W-1:0] QUARTER_TICKS_RESET = 16'd500;
   localparam logic [VOL_W-1:0]   START_VOLUME_RESET  = 8'd127;

   // event codes
   localparam logic [CODE_W-1:0] CODE_REST        = 8'd128;
   localparam logic [CODE_W-1:0] CODE_PROGRAM     = 8'd129;
   localparam logic [CODE_W-1:0] CODE_PROGRAM_ALT = 8'd134;
   localparam logic [CODE_W-1:0] CODE_VOLUME      = 8'd132;

   // note data byte layout
   localparam int CHORD_BIT = 7;
   localparam int TIE_BIT   = 6;
   localparam int TUP_LSB   = 4;
   localparam int DOT_BIT   = 3;
   localparam int DIVN_LSB  = 0;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PROGRAM  = 2'd2;

   typedef struct packed {
      logic              track_start;
      logic [CODE_W-1:0] event_code;
      logic [DATA_W-1:0] event_data;
   } req_item_type;

   typedef struct packed {
      logic [OUT_TIME_W-1:0] event_time;
      logic [KIND_W-1:0]     event_kind;
      logic [7:0]            key_or_program;
      logic [VOL_W-1:0]      note_velocity;
      logic                  tied_out;
      logic                  last_of_run;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CLS_NOTE,
      CLS_REST,
      CLS_PROGRAM,
      CLS_VOLUME,
      CLS_OTHER
   } code_class_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE,
      S_MUL,
      S_CORR,
      S_WORK,
      S_NOTE_OFF
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic calc_base;
      logic calc_mul;
      logic calc_corr;
      logic calc_off;
      logic push_on;
      logic push_off;
      logic push_prg;
      logic advance;
      logic set_vol;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      code_class_type cls;
      logic           tup_nz;
      logic           out_free;
   } dp_status_type;

   // sort an event code into its handling class
   function automatic code_class_type code_class(input logic [CODE_W-1:0] code);
      code_class_type cls;
      case (code) inside
         [8'd0:8'd127]:                   cls = CLS_NOTE;
         CODE_REST:                       cls = CLS_REST;
         CODE_PROGRAM, CODE_PROGRAM_ALT:  cls = CLS_PROGRAM;
         CODE_VOLUME:                     cls = CLS_VOLUME;
         default:                         cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   // floor(2^24 / (2n+1)) for the tuplet divide by 3, 5 or 7
   function automatic logic [RECIP_W-1:0] tuplet_recip(input logic [TUP_W-1:0] tup);
      logic [RECIP_W-1:0] r;
      case (tup)
         2'd1:    r = 23'd5592405;
         2'd2:    r = 23'd3355443;
         2'd3:    r = 23'd2396745;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> design/sevnote_ctrl.sv
// sequencing state machine for the score event decoder
// depends on sevnote_pkg; drives the datapath by dp_cmd_type commands
module sevnote_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sevnote_pkg::dp_status_type status,
   output sevnote_pkg::dp_cmd_type    cmd
);
   import sevnote_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_BASE;
         end
         S_BASE: begin
            state_in = status.tup_nz ? S_MUL : S_WORK;
         end
         S_MUL: begin
            state_in = S_CORR;
         end
         S_CORR: begin
            state_in = S_WORK;
         end
         S_WORK: begin
            case (status.cls)
               CLS_NOTE:    if (status.out_free) state_in = S_NOTE_OFF;
               CLS_PROGRAM: if (status.out_free) state_in = S_IDLE;
               default:     state_in = S_IDLE;
            endcase
         end
         S_NOTE_OFF: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_BASE: begin
            cmd.calc_base = 1'b1;
         end
         S_MUL: begin
            cmd.calc_mul = 1'b1;
         end
         S_CORR: begin
            cmd.calc_corr = 1'b1;
         end
         S_WORK: begin
            cmd.calc_off = 1'b1;
            case (status.cls)
               CLS_NOTE:    cmd.push_on  = status.out_free;
               CLS_REST:    cmd.advance  = 1'b1;
               CLS_PROGRAM: cmd.push_prg = status.out_free;
               CLS_VOLUME:  cmd.set_vol  = 1'b1;
               default:     cmd          = cmd;
            endcase
         end
         S_NOTE_OFF: begin
            cmd.push_off = status.out_free;
            cmd.advance  = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // accepted item always starts with the base duration step
   a_load_to_base: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_BASE)
      else $error("accepted item did not move to base step");

   // the divide correction follows the reciprocal multiply directly
   a_mul_to_corr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |=> state_ff == S_CORR)
      else $error("reciprocal multiply not followed by correction");

   // note-off stage is only reached after the note-on stage
   a_off_after_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NOTE_OFF && !$past(reset)) |->
         ($past(state_ff) == S_WORK || $past(state_ff) == S_NOTE_OFF))
      else $error("note-off stage entered out of order");

endmodule

>>> design/sevnote_dp.sv
// datapath: config registers, time and volume state, duration math, result register
// depends on sevnote_pkg; commanded by sevnote_ctrl
module sevnote_dp #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [sevnote_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sevnote_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  sevnote_pkg::req_item_type            req_item,
   input  sevnote_pkg::dp_cmd_type              cmd,
   output sevnote_pkg::dp_status_type           status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sevnote_pkg::rsp_item_type            rsp_item
);
   import sevnote_pkg::*;

   localparam int SUM_W = (TIME_WIDTH > SCALED_W) ? TIME_WIDTH : SCALED_W;
   localparam int EXT_W = (TIME_WIDTH > OUT_TIME_W) ? TIME_WIDTH : OUT_TIME_W;

   // config registers
   logic [QTICK_W-1:0] quarter_ticks_ff;
   logic [VOL_W-1:0]   start_volume_ff;

   // block state
   logic [TIME_WIDTH-1:0] time_ff;
   logic [TIME_WIDTH-1:0] time_in;
   logic [VOL_W-1:0]      vol_ff;

   // captured item and working values
   logic [CODE_W-1:0]     code_ff;
   logic [DATA_W-1:0]     data_ff;
   logic [DUR_W-1:0]      dur_ff;
   logic [DUR_W-1:0]      dur_in;
   logic [SCALED_W-1:0]   scaled_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [TIME_WIDTH-1:0] off_ff;

   // result register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   // decoded data byte
   logic              chord;
   logic              tie;
   logic [TUP_W-1:0]  tup;
   logic              dot;
   logic [DIVN_W-1:0] divn;
   logic [TDIV_W-1:0] tdiv;

   logic [DUR_W-1:0]      base_raw;
   logic [SCALED_W-1:0]   scaled_in;
   logic [SCALED_W-1:0]   quot_est;
   logic [SCALED_W+TDIV_W-1:0] quot_mul;
   logic [SCALED_W-1:0]   rem_est;
   logic                  rem_over;
   logic [SCALED_W-1:0]   rem_fix;
   logic [SCALED_W-1:0]   quot_fix;
   logic [SCALED_W-1:0]   dur_x7;
   logic [SUM_W-1:0]      off_sum;
   logic [SUM_W-1:0]      adv_sum;
   logic [EXT_W-1:0]      time_ext;
   logic [EXT_W-1:0]      off_ext;
   logic                  any_push;

   assign chord = data_ff[CHORD_BIT];
   assign tie   = data_ff[TIE_BIT];
   assign tup   = data_ff[TUP_LSB +: TUP_W];
   assign dot   = data_ff[DOT_BIT];
   assign divn  = data_ff[DIVN_LSB +: DIVN_W];
   assign tdiv  = {tup, 1'b1};

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ticks_ff <= QUARTER_TICKS_RESET;
         start_volume_ff  <= START_VOLUME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUARTER_TICKS: quarter_ticks_ff <= csr_wdata[QTICK_W-1:0];
            CSR_START_VOLUME:  start_volume_ff  <= csr_wdata[VOL_W-1:0];
            default:           quarter_ticks_ff <= quarter_ticks_ff;
         endcase
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= req_item.event_code;
         data_ff <= req_item.event_data;
      end
   end

   // base duration: ticks * 4 or * 6, shifted down by division
   assign base_raw = ({1'b0, quarter_ticks_ff, 2'b00}
                      + (dot ? {2'b00, quarter_ticks_ff, 1'b0} : '0)) >> divn;

   // tuplet scale d * 2n, then multiply by 1/(2n+1)
   assign scaled_in = SCALED_W'(dur_ff) * SCALED_W'({tup, 1'b0});

   // reciprocal estimate is the true quotient or one below it
   assign quot_est = prod_ff[RECIP_SHIFT +: SCALED_W];
   assign quot_mul = quot_est * tdiv;
   assign rem_est  = scaled_ff - quot_mul[SCALED_W-1:0];
   assign rem_over = rem_est >= SCALED_W'(tdiv);
   assign rem_fix  = rem_over ? rem_est - SCALED_W'(tdiv) : rem_est;
   assign quot_fix = quot_est + SCALED_W'(rem_over);

   always_comb begin
      dur_in = dur_ff;
      if (cmd.calc_base) dur_in = base_raw;
      if (cmd.calc_corr) dur_in = quot_fix[DUR_W-1:0];
   end

   // duration pipeline registers
   always_ff @(posedge clock) begin
      dur_ff <= dur_in;
      if (cmd.calc_mul) begin
         scaled_ff <= scaled_in;
         prod_ff   <= scaled_in * tuplet_recip(tup);
      end
   end

   // note-off time: current time plus 7/8 of the duration
   assign dur_x7  = {dur_ff, 3'b000} - SCALED_W'(dur_ff);
   assign off_sum = SUM_W'(time_ff) + SUM_W'(dur_x7[SCALED_W-1:3]);
   assign adv_sum = SUM_W'(time_ff) + SUM_W'(dur_ff);

   always_ff @(posedge clock) begin
      if (cmd.calc_off) off_ff <= off_sum[TIME_WIDTH-1:0];
   end

   // running time and volume
   always_comb begin
      time_in = time_ff;
      if (cmd.load && req_item.track_start) time_in = '0;
      if (cmd.advance && !chord) time_in = adv_sum[TIME_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         vol_ff  <= START_VOLUME_RESET;
      end else begin
         time_ff <= time_in;
         if (cmd.load && req_item.track_start) begin
            vol_ff <= start_volume_ff;
         end else if (cmd.set_vol) begin
            vol_ff <= data_ff;
         end
      end
   end

   // result item build
   assign time_ext = EXT_W'(time_ff);
   assign off_ext  = EXT_W'(off_ff);
   assign any_push = cmd.push_on || cmd.push_off || cmd.push_prg;

   always_comb begin
      rsp_item_in                = '0;
      rsp_item_in.event_time     = time_ext[OUT_TIME_W-1:0];
      rsp_item_in.key_or_program = code_ff;
      if (cmd.push_on) begin
         rsp_item_in.event_kind    = KIND_NOTE_ON;
         rsp_item_in.note_velocity = vol_ff;
      end else if (cmd.push_off) begin
         rsp_item_in.event_time  = off_ext[OUT_TIME_W-1:0];
         rsp_item_in.event_kind  = KIND_NOTE_OFF;
         rsp_item_in.tied_out    = tie;
         rsp_item_in.last_of_run = 1'b1;
      end else begin
         rsp_item_in.event_kind     = KIND_PROGRAM;
         rsp_item_in.key_or_program = data_ff;
         rsp_item_in.last_of_run    = 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (any_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (any_push) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_item_ff;
   assign status.cls      = code_class(code_ff);
   assign status.tup_nz   = tup != '0;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // a push never overwrites a result that is still waiting
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      any_push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // only one result loaded per cycle
   a_one_push: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push_on, cmd.push_off, cmd.push_prg}))
      else $error("more than one result push");

   // corrected remainder lands below the tuplet divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_corr |-> rem_fix < SCALED_W'(tdiv))
      else $error("tuplet quotient correction out of range");

endmodule

>>> design/score_event_to_note_events.sv
// top level of the score event to note event decoder
// depends on sevnote_pkg, sevnote_ctrl and sevnote_dp
//
//   port group   direction   handshake          payload
//   req_         in          req_valid/ready    req_item_type
//   rsp_         out         rsp_valid/ready    rsp_item_type
//   csr_         in          csr_we             csr_index, csr_wdata
//
// one item at a time: every item passes the base and work steps, a note
// then the note-off step; a tuplet adds the reciprocal multiply and correction
// a note holds two results, each waiting on the single output register
// reset is synchronous; time clears to zero, volume and registers load defaults
// a stall on rsp_ready holds the sequencer in the push step; req_ready is low then
module score_event_to_note_events #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sevnote_pkg::req_item_type           req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sevnote_pkg::rsp_item_type           rsp_item,
   input  logic                                csr_we,
   input  logic [sevnote_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sevnote_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sevnote_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   sevnote_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sevnote_dp #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
